FILE: sv/sobel_edge_normalized_assert.svh
// assertion macros for the sobel edge block
// no dependencies; included by the top level
`ifndef SOBEL_EDGE_NORMALIZED_ASSERT_SVH
`define SOBEL_EDGE_NORMALIZED_ASSERT_SVH

// condition must hold at every edge outside reset
`define SEN_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SEN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sen_pkg.sv
// shared widths, codes and kernel coefficients for the sobel edge block
// no dependencies
`default_nettype none
package sen_pkg;
  localparam int CFG_W          = 9;
  localparam int PIX_W          = 8;
  localparam int MAG_W          = 11;
  localparam int EDGE_W         = 8;
  localparam int GRAD_W         = 12;
  localparam int SQ_W           = 22;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic signed [2:0] coef_t;

  // horizontal kernel: columns +1 0 -1, middle row doubled
  function automatic coef_t kern_x(input logic [1:0] i, input logic [1:0] j);
    coef_t v;
    v = (j == 2'd0) ? 3'sd1 : (j == 2'd2) ? -3'sd1 : 3'sd0;
    if (i == 2'd1) v = v <<< 1;
    return v;
  endfunction

  // vertical kernel: rows -1 0 +1, middle column doubled
  function automatic coef_t kern_y(input logic [1:0] i, input logic [1:0] j);
    coef_t v;
    v = (i == 2'd0) ? -3'sd1 : (i == 2'd2) ? 3'sd1 : 3'sd0;
    if (j == 2'd1) v = v <<< 1;
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: sv/sen_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module sen_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/sen_isqrt.sv
// iterative integer square root, two radicand bits per cycle
// no dependencies
`default_nettype none
module sen_isqrt #(
  parameter int IN_W  = 22,
  parameter int OUT_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [IN_W-1:0]  radicand,
  output logic                  done,
  output logic      [OUT_W-1:0] root
);
  localparam int STEPS = IN_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [IN_W-1:0]  rem_r, root_r, bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [IN_W-1:0]  trial;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= radicand;
        root_r <= '0;
        bit_r  <= IN_W'(1) << (IN_W - 2);
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r[OUT_W-1:0];
endmodule
`default_nettype wire

FILE: sv/sen_div.sv
// iterative restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module sen_div #(
  parameter int N_W = 19,
  parameter int D_W = 11
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic      [N_W-1:0] quotient
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo_r;
  logic [D_W:0]     rem_r;
  logic [D_W-1:0]   den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [D_W:0]     rem_sh;

  assign rem_sh = {rem_r[D_W-1:0], quo_r[N_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[N_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[N_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

FILE: sv/sobel_edge_normalized.sv
// top level of the normalized sobel edge block: sequencer, gradient datapath, stores
// depends on sen_pkg, sen_ram, sen_isqrt, sen_div and sobel_edge_normalized_assert.svh
//
// usage:
//  in channel: in_tuser = command (0 load pixel, 1 read edge), in_tdata = gray pixel.
//  loads write the frame in raster order, one transaction per cycle while
//  in_tready is high; loads past the frame and reads before the frame is full are
//  dropped with no result. the first read after the frame is full runs the gradient
//  pass: per pixel 9 neighbor reads from the pixel ram, a drain step, both gradients
//  squared on the shared squarer, a square root start, the square root and a store.
//  every read then keeps in_tready low through the magnitude ram fetch, the divider
//  start, the division and the output step, with the divider skipped when the frame
//  maximum is zero, and yields one out transaction.
//  out channel: out_tdata = edge value, out_tlast = last pixel of the frame.
//  the result sits in an output register; a stalled receiver holds it, loads and
//  reads are still taken, and the next read result waits in the output step with
//  in_tready low until the held result is taken.
//  in_tready is low while a pass or a read is in progress and in the cycle after
//  a configuration write.
//  cfg port: index 0 frame width, 1 frame height; a write restarts the frame.
//  reset (synchronous, rst_n low) restores a 256 x 256 frame and empties it;
//  the rams need no clearing since every entry is written before it is read.
`default_nettype none
module sobel_edge_normalized #(
  parameter int MAX_WIDTH  = sen_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sen_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [sen_pkg::PIX_W-1:0]   in_tdata,   // [7:0] gray_pixel
  input  wire logic                        in_tuser,   // [0] command
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [sen_pkg::EDGE_W-1:0]  out_tdata,  // [7:0] edge_value
  output logic                             out_tlast,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_addr,
  input  wire logic [sen_pkg::CFG_W-1:0]   cfg_wdata
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int GW    = sen_pkg::GRAD_W;
  localparam int MW    = sen_pkg::MAG_W;
  localparam int SW    = sen_pkg::SQ_W;
  localparam int NW    = MW + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_GRAD, S_GLAST, S_SQX, S_SQY, S_ROOT, S_ROOTW, S_STORE,
    S_FETCH, S_FWAIT, S_DIVGO, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // frame geometry
  logic [WW-1:0] eff_w_r;
  logic [HW-1:0] eff_h_r;
  logic [PW-1:0] total_r;
  logic          cfg_busy_r;

  // frame positions and flags
  logic [PW-1:0] load_pos_r, read_pos_r;
  logic          mag_ready_r;
  logic [MW-1:0] peak_r;

  // gradient pass counters
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [AW-1:0] base_r;
  logic [1:0]    ni_r, nj_r;

  // tap pipeline and accumulators
  logic                 tap_pend_r, tap_ok_r;
  sen_pkg::coef_t       kx_r, ky_r;
  logic signed [GW-1:0] gx_r, gy_r;
  logic [SW-1:0]        sq_r;
  logic [MW-1:0]        mag_r;
  logic [7:0]           edge_r;

  logic                      out_valid_r, out_last_r;
  logic [sen_pkg::EDGE_W-1:0] out_data_r;

  // ram and unit wiring
  logic [AW-1:0]             pix_raddr, mag_raddr;
  logic [sen_pkg::PIX_W-1:0] pix_rdata;
  logic [MW-1:0]             mag_rdata, root;
  logic                      load_we, root_done, div_done;
  logic [NW-1:0]             quotient, dividend;

  logic accept, is_load, is_read;
  assign in_tready = (state_r == S_IDLE) && !cfg_busy_r;
  assign accept    = in_tvalid && in_tready;
  assign is_load   = accept && (in_tuser == sen_pkg::CMD_LOAD);
  assign is_read   = accept && (in_tuser == sen_pkg::CMD_READ) && (load_pos_r >= total_r);
  assign load_we   = is_load && (load_pos_r < total_r);

  // neighbor address and bounds for the current tap
  logic [AW-1:0] w_ext, row_addr;
  logic          tap_ok, last_tap, last_pix, pix_last_col;
  assign w_ext    = AW'(eff_w_r);
  assign row_addr = (ni_r == 2'd0) ? base_r - w_ext :
                    (ni_r == 2'd2) ? base_r + w_ext : base_r;
  assign pix_raddr = row_addr + AW'(nj_r) - AW'(1);
  assign tap_ok = !((ni_r == 2'd0) && (row_r == '0)) &&
                  !((ni_r == 2'd2) && (HW'(row_r) + HW'(1) >= eff_h_r)) &&
                  !((nj_r == 2'd0) && (col_r == '0)) &&
                  !((nj_r == 2'd2) && (WW'(col_r) + WW'(1) >= eff_w_r));
  assign last_tap     = (ni_r == 2'd2) && (nj_r == 2'd2);
  assign pix_last_col = (WW'(col_r) + WW'(1) == eff_w_r);
  assign last_pix     = pix_last_col && (HW'(row_r) + HW'(1) == eff_h_r);

  // weighted tap, zero outside the frame
  logic signed [GW-1:0] px, tx, ty;
  assign px = $signed({{(GW - sen_pkg::PIX_W){1'b0}}, pix_rdata});
  assign tx = tap_ok_r ? GW'(px * GW'(kx_r)) : '0;
  assign ty = tap_ok_r ? GW'(px * GW'(ky_r)) : '0;

  // shared squarer
  logic [MW-1:0] abs_x, abs_y, sq_op;
  logic [SW-1:0] sq_prod;
  assign abs_x   = MW'(gx_r[GW-1] ? -gx_r : gx_r);
  assign abs_y   = MW'(gy_r[GW-1] ? -gy_r : gy_r);
  assign sq_op   = (state_r == S_SQX) ? abs_x : abs_y;
  assign sq_prod = SW'(sq_op * sq_op);

  assign mag_raddr = read_pos_r[AW-1:0];
  assign dividend  = {mag_rdata, 8'b0} - NW'(mag_rdata);

  logic read_last;
  assign read_last = (read_pos_r + PW'(1) >= total_r);

  sen_ram #(.WIDTH(sen_pkg::PIX_W), .DEPTH(DEPTH)) u_pix_ram (
    .clk(clk), .we(load_we), .waddr(load_pos_r[AW-1:0]), .wdata(in_tdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  sen_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_mag_ram (
    .clk(clk), .we(state_r == S_STORE), .waddr(base_r), .wdata(mag_r),
    .raddr(mag_raddr), .rdata(mag_rdata)
  );

  sen_isqrt #(.IN_W(SW), .OUT_W(MW)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_ROOT), .radicand(sq_r),
    .done(root_done), .root(root)
  );

  sen_div #(.N_W(NW), .D_W(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DIVGO), .dividend(dividend),
    .divisor(peak_r), .done(div_done), .quotient(quotient)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (is_read) state_nxt = mag_ready_r ? S_FETCH : S_GRAD;
      S_GRAD:  if (last_tap) state_nxt = S_GLAST;
      S_GLAST: state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_ROOT;
      S_ROOT:  state_nxt = S_ROOTW;
      S_ROOTW: if (root_done) state_nxt = S_STORE;
      S_STORE: state_nxt = last_pix ? S_FETCH : S_GRAD;
      S_FETCH: state_nxt = S_FWAIT;
      S_FWAIT: state_nxt = (peak_r == '0) ? S_OUT : S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eff_w_r     <= WW'(MAX_WIDTH < 256 ? MAX_WIDTH : 256);
      eff_h_r     <= HW'(MAX_HEIGHT < 256 ? MAX_HEIGHT : 256);
      total_r     <= PW'((MAX_WIDTH < 256 ? MAX_WIDTH : 256) *
                         (MAX_HEIGHT < 256 ? MAX_HEIGHT : 256));
      cfg_busy_r  <= 1'b0;
      load_pos_r  <= '0;
      read_pos_r  <= '0;
      mag_ready_r <= 1'b0;
      peak_r      <= '0;
      tap_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cfg_busy_r <= cfg_we;
      total_r    <= PW'(eff_w_r * eff_h_r);

      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (load_we) load_pos_r <= load_pos_r + PW'(1);

      // start of the gradient pass
      if (state_r == S_IDLE && is_read && !mag_ready_r) begin
        col_r  <= '0;
        row_r  <= '0;
        base_r <= '0;
        ni_r   <= '0;
        nj_r   <= '0;
        peak_r <= '0;
        gx_r   <= '0;
        gy_r   <= '0;
      end

      // issue one tap read per cycle, accumulate the previous one
      tap_pend_r <= (state_r == S_GRAD);
      tap_ok_r   <= tap_ok;
      kx_r       <= sen_pkg::kern_x(ni_r, nj_r);
      ky_r       <= sen_pkg::kern_y(ni_r, nj_r);
      if (tap_pend_r) begin
        gx_r <= gx_r + tx;
        gy_r <= gy_r + ty;
      end
      if (state_r == S_GRAD) begin
        if (nj_r == 2'd2) begin
          nj_r <= '0;
          ni_r <= (ni_r == 2'd2) ? 2'd0 : ni_r + 2'd1;
        end else begin
          nj_r <= nj_r + 2'd1;
        end
      end

      if (state_r == S_SQX) sq_r <= sq_prod;
      if (state_r == S_SQY) sq_r <= sq_r + sq_prod;
      if (root_done) mag_r <= root;

      // store magnitude, track the peak, step to the next pixel
      if (state_r == S_STORE) begin
        if (mag_r > peak_r) peak_r <= mag_r;
        gx_r   <= '0;
        gy_r   <= '0;
        base_r <= base_r + AW'(1);
        if (pix_last_col) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
        if (last_pix) mag_ready_r <= 1'b1;
      end

      if (state_r == S_FWAIT && peak_r == '0) edge_r <= '0;
      if (div_done) edge_r <= (quotient > NW'(255)) ? 8'd255 : quotient[7:0];

      // hand the result over and advance or restart the frame
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= edge_r;
        out_last_r  <= read_last;
        if (read_last) begin
          load_pos_r  <= '0;
          read_pos_r  <= '0;
          mag_ready_r <= 1'b0;
          peak_r      <= '0;
        end else begin
          read_pos_r <= read_pos_r + PW'(1);
        end
      end

      // configuration write clamps the size and restarts the frame
      if (cfg_we) begin
        load_pos_r  <= '0;
        read_pos_r  <= '0;
        mag_ready_r <= 1'b0;
        peak_r      <= '0;
        if (cfg_addr == sen_pkg::REG_FRAME_WIDTH) begin
          eff_w_r <= (cfg_wdata == '0) ? WW'(1) :
                     (32'(cfg_wdata) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_wdata);
        end else begin
          eff_h_r <= (cfg_wdata == '0) ? HW'(1) :
                     (32'(cfg_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata);
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `include "sobel_edge_normalized_assert.svh"

  `SEN_ASSERT_NEXT(a_full_load_dropped,
    is_load && !load_we && !cfg_we && state_r == S_IDLE, $stable(load_pos_r),
    "load past the frame moved the load position")
  `SEN_ASSERT_ALWAYS(a_read_in_frame, !mag_ready_r || read_pos_r < total_r,
    "read position beyond frame while magnitudes ready")
  `SEN_ASSERT_NEXT(a_out_from_seq, !out_valid_r, !out_valid_r || $past(state_r == S_OUT),
    "result appeared without the output step")
endmodule
`default_nettype wire

FILE: bench/sobel_edge_normalized_tb.sv
// self-checking bench for the normalized sobel edge block
// depends on sen_pkg and the sobel_edge_normalized top level
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_normalized_tb;

  localparam int STORE_DEPTH = sen_pkg::DEF_MAX_WIDTH * sen_pkg::DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic                      cmd;
    logic [sen_pkg::PIX_W-1:0] pix;
  } pixel_cmd_t;

  typedef struct packed {
    logic [sen_pkg::EDGE_W-1:0] edge_val;
    logic                       last;
  } edge_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [sen_pkg::PIX_W-1:0]    in_tdata;   // [7:0] gray_pixel
  logic                         in_tuser;   // [0] command
  logic                         out_tvalid;
  logic                         out_tready;
  logic [sen_pkg::EDGE_W-1:0]   out_tdata;  // [7:0] edge_value
  logic                         out_tlast;
  logic                         cfg_we;
  logic                         cfg_addr;
  logic [sen_pkg::CFG_W-1:0]    cfg_wdata;

  sobel_edge_normalized uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // shadow copy of the block state
  logic [sen_pkg::CFG_W-1:0] sh_width, sh_height;
  logic [sen_pkg::PIX_W-1:0] sh_pixels [STORE_DEPTH];
  logic [sen_pkg::MAG_W-1:0] sh_mags   [STORE_DEPTH];
  int unsigned               sh_peak, sh_load_pos, sh_read_pos;
  bit                        sh_ready;

  pixel_cmd_t   pending_q[$];
  edge_result_t edge_expect_q[$];
  int           failures;
  int           send_idle_pct, recv_stall_pct;
  int           hold_token, hold_seen, hold_left;
  bit           in_took;
  int unsigned  cycle_count;

  function automatic int unsigned clamp_dim(input logic [sen_pkg::CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > sen_pkg::DEF_MAX_WIDTH) return sen_pkg::DEF_MAX_WIDTH;
    return v;
  endfunction

  // bitwise integer square root, floor
  function automatic int unsigned int_sqrt(input int unsigned v);
    int unsigned root, bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void restart_shadow();
    sh_peak = 0;
    sh_load_pos = 0;
    sh_read_pos = 0;
    sh_ready = 0;
  endfunction

  // gradient pass over the whole frame, zero outside the border
  function automatic void compute_gradients();
    int w, h, gx, gy, rr, cc, p, kx, ky;
    int unsigned m;
    w = clamp_dim(sh_width);
    h = clamp_dim(sh_height);
    sh_peak = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        gx = 0;
        gy = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            rr = r - 1 + i;
            cc = c - 1 + j;
            if (rr >= 0 && cc >= 0 && rr < h && cc < w) begin
              p = sh_pixels[rr * w + cc];
              kx = (j == 0) ? 1 : (j == 2) ? -1 : 0;
              if (i == 1) kx = kx * 2;
              ky = (i == 0) ? -1 : (i == 2) ? 1 : 0;
              if (j == 1) ky = ky * 2;
              gx += p * kx;
              gy += p * ky;
            end
          end
        end
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        m = int_sqrt(gx * gx + gy * gy) & 11'h7ff;
        sh_mags[r * w + c] = sen_pkg::MAG_W'(m);
        if (m > sh_peak) sh_peak = m;
      end
    end
    sh_ready = 1;
  endfunction

  // predict the effect of one accepted transaction
  function automatic void predict_edge(input pixel_cmd_t it);
    int unsigned total, val;
    edge_result_t res;
    total = clamp_dim(sh_width) * clamp_dim(sh_height);
    if (it.cmd == sen_pkg::CMD_LOAD) begin
      if (sh_load_pos < total) begin
        sh_pixels[sh_load_pos] = it.pix;
        sh_load_pos++;
      end
      return;
    end
    if (sh_load_pos < total) return;   // read before the frame is full
    if (!sh_ready) compute_gradients();
    val = (sh_peak == 0) ? 0 : (sh_mags[sh_read_pos] * 255) / sh_peak;
    if (val > 255) val = 255;
    res.edge_val = sen_pkg::EDGE_W'(val);
    res.last = (sh_read_pos + 1 >= total);
    edge_expect_q.push_back(res);
    if (res.last) restart_shadow();
    else sh_read_pos++;
  endfunction

  // monitor: input acceptance, config writes and result checking at the rising edge
  always @(posedge clk) begin
    edge_result_t exp_res;
    pixel_cmd_t it;
    in_took = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_addr == sen_pkg::REG_FRAME_WIDTH) sh_width = cfg_wdata;
        else sh_height = cfg_wdata;
        restart_shadow();
      end
      if (in_tvalid && in_tready) begin
        it.cmd = in_tuser;
        it.pix = in_tdata;
        predict_edge(it);
        in_took = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (edge_expect_q.size() == 0) begin
          $error("unexpected result transaction edge_value=%0d", out_tdata);
          failures++;
        end else begin
          exp_res = edge_expect_q.pop_front();
          if (out_tdata !== exp_res.edge_val) begin
            $error("edge_value expected %0d actual %0d", exp_res.edge_val, out_tdata);
            failures++;
          end
          if (out_tlast !== exp_res.last) begin
            $error("last_pixel expected %0d actual %0d", exp_res.last, out_tlast);
            failures++;
          end
        end
      end
    end
  end

  // driver: next pending transaction offered at the falling edge
  always @(negedge clk) begin
    pixel_cmd_t it;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_q.pop_front();
        in_tuser  <= it.cmd;
        in_tdata  <= it.pix;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off each time hold_token changes
  always @(negedge clk) begin
    bit rdy;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(99) >= recv_stall_pct);
    end
    out_tready <= rdy;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [sen_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every transaction is taken and every result has come back
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_tvalid || edge_expect_q.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);   // dropped transactions may still be in flight
  endtask

  function automatic logic [sen_pkg::PIX_W-1:0] pick_pixel(input int style);
    case (style)
      0: return 8'd0;
      1: return 8'd255;
      2: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: return sen_pkg::PIX_W'($urandom_range(255));
    endcase
  endfunction

  // queue one frame: loads, optional noise, then reads (possibly cut short)
  task automatic queue_frame(input int w, input int h, input int style, input bit noise,
                             input bit cut);
    pixel_cmd_t it;
    int total, nreads;
    total = w * h;
    for (int k = 0; k < total; k++) begin
      if (noise && $urandom_range(9) == 0) begin
        it.cmd = sen_pkg::CMD_READ;       // read before full, dropped
        it.pix = sen_pkg::PIX_W'($urandom_range(255));
        pending_q.push_back(it);
      end
      it.cmd = sen_pkg::CMD_LOAD;
      it.pix = pick_pixel(style);
      pending_q.push_back(it);
    end
    nreads = cut ? $urandom_range(total - 1) : total;
    for (int k = 0; k < nreads; k++) begin
      if (noise && $urandom_range(9) == 0) begin
        it.cmd = sen_pkg::CMD_LOAD;       // load past the frame, dropped
        it.pix = sen_pkg::PIX_W'($urandom_range(255));
        pending_q.push_back(it);
      end
      it.cmd = sen_pkg::CMD_READ;
      it.pix = sen_pkg::PIX_W'($urandom_range(255));
      pending_q.push_back(it);
    end
  endtask

  task automatic run_frame(input logic [sen_pkg::CFG_W-1:0] wr,
                           input logic [sen_pkg::CFG_W-1:0] hr,
                           input int style, input bit noise, input bit cut);
    write_reg(sen_pkg::REG_FRAME_WIDTH, wr);
    write_reg(sen_pkg::REG_FRAME_HEIGHT, hr);
    queue_frame(clamp_dim(wr), clamp_dim(hr), style, noise, cut);
    wait_drained();
  endtask

  initial begin
    int sent, mode, w, h, style;
    logic [sen_pkg::CFG_W-1:0] wr, hr;
    failures = 0;
    cycle_count = 0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = sen_pkg::CMD_LOAD;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = sen_pkg::REG_FRAME_WIDTH;
    cfg_wdata = '0;
    sh_width = sen_pkg::DEF_MAX_WIDTH;
    sh_height = sen_pkg::DEF_MAX_HEIGHT;
    restart_shadow();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: zero width register clamps to one, single pixel, zero maximum
    run_frame(9'd0, 9'd1, 1, 1'b0, 1'b0);
    // 3x3 all black, all white, then a 2x3 black and white pattern with dropped transactions
    run_frame(9'd3, 9'd3, 0, 1'b0, 1'b0);
    run_frame(9'd3, 9'd3, 1, 1'b0, 1'b0);
    run_frame(9'd2, 9'd3, 2, 1'b1, 1'b0);

    // long receiver hold-off: the parked result backs up the input
    hold_token++;
    run_frame(9'd4, 9'd3, 3, 1'b1, 1'b0);

    // random frames, rotating through the idling modes
    sent = 0;
    mode = 0;
    while (sent < 900) begin
      case (mode % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      mode++;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      wr = sen_pkg::CFG_W'(w);
      hr = sen_pkg::CFG_W'(h);
      case ($urandom_range(39))
        0: begin wr = 9'd511; hr = 9'd1; w = 256; h = 1; end   // clamps to full width
        1: begin wr = 9'd1; hr = 9'd256; w = 1; h = 256; end
        2: begin wr = 9'd0; w = 1; end
        3: begin hr = 9'd300; hr[0] = 1'($urandom_range(1)); h = 256; wr = 9'd1; w = 1; end
        default: ;
      endcase
      style = ($urandom_range(9) < 7) ? 3 : $urandom_range(2);
      run_frame(wr, hr, style, $urandom_range(3) == 0, $urandom_range(7) == 0);
      sent += 2 * w * h;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
